### rtl/aesd_pkg.sv
// Package: AES-128 decryption types, tables and round functions.
package aesd_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKeyMode = 2'd2;

  typedef logic [127:0] block_t;

  // Word handed from one round cell to the next
  typedef struct packed {
    logic   vld;
    block_t state;
    block_t rkey;
  } cell_word_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte i of a block (byte 0 in the top bits)
  function automatic logic [7:0] byte_of(input block_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  // Round key i -> round key i+1
  function automatic block_t key_fwd(input block_t k, input logic [7:0] rc);
    logic [7:0] b [16];
    block_t o;
    for (int i = 0; i < 16; i++) b[i] = byte_of(k, i);
    b[0] = b[0] ^ fwd_sbox(b[13]) ^ rc;
    b[1] = b[1] ^ fwd_sbox(b[14]);
    b[2] = b[2] ^ fwd_sbox(b[15]);
    b[3] = b[3] ^ fwd_sbox(b[12]);
    for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = b[i];
    return o;
  endfunction

  // Round key i -> round key i-1
  function automatic block_t key_bwd(input block_t k, input logic [7:0] rc);
    logic [7:0] b [16];
    block_t o;
    for (int i = 0; i < 16; i++) b[i] = byte_of(k, i);
    for (int i = 15; i >= 4; i--) b[i] = b[i] ^ b[i-4];
    b[0] = b[0] ^ fwd_sbox(b[13]) ^ rc;
    b[1] = b[1] ^ fwd_sbox(b[14]);
    b[2] = b[2] ^ fwd_sbox(b[15]);
    b[3] = b[3] ^ fwd_sbox(b[12]);
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = b[i];
    return o;
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = inv_sbox(byte_of(s, 4*((c-r+4)%4)+r));
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t inv_mix(input block_t s);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = byte_of(s, 4*c+r);
        m2[r] = xt(a[r]);
        m4[r] = xt(m2[r]);
        m8[r] = xt(m4[r]);
      end
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = (m8[r] ^ m4[r] ^ m2[r])
            ^ (m8[(r+1)%4] ^ m2[(r+1)%4] ^ a[(r+1)%4])
            ^ (m8[(r+2)%4] ^ m4[(r+2)%4] ^ a[(r+2)%4])
            ^ (m8[(r+3)%4] ^ a[(r+3)%4]);
      end
    end
    return o;
  endfunction

endpackage

### rtl/aesd_if.sv
// Interfaces: block stream channel and configuration write channel.
interface aesd_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, data_high, data_low, input ready);
  modport sink (input valid, data_high, data_low, output ready);
endinterface

interface aesd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [aesd_pkg::CfgIdxW-1:0]  index;
  logic [63:0]                   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/aesd_kexp_cell.sv
// Key expansion cell: one forward key-schedule step on its input round key.
module aesd_kexp_cell (
  input  logic                 clk_i,
  input  logic [3:0]           step_i,
  input  aesd_pkg::block_t     key_i,
  output aesd_pkg::block_t     key_o
);
  aesd_pkg::block_t key_d, key_q;

  // advance the key one round
  assign key_d = aesd_pkg::key_fwd(key_i, aesd_pkg::rcon(step_i));

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
endmodule

### rtl/aesd_round_cell.sv
// Round cell: one inverse round plus the matching backward key step.
module aesd_round_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [3:0]            rnd_i,
  input  logic                  last_i,
  input  aesd_pkg::cell_word_t  word_i,
  output aesd_pkg::cell_word_t  word_o
);
  aesd_pkg::block_t  rk_n, sb, ak;
  aesd_pkg::cell_word_t word_d;
  logic              vld_q;
  aesd_pkg::block_t  state_q, rkey_q;

  // derive previous round key, then apply the inverse round
  always_comb begin
    rk_n = aesd_pkg::key_bwd(word_i.rkey, aesd_pkg::rcon(rnd_i - 4'd1));
    sb   = aesd_pkg::inv_sub_shift(word_i.state);
    ak   = sb ^ rk_n;
    word_d.vld   = word_i.vld;
    word_d.rkey  = rk_n;
    word_d.state = last_i ? ak : aesd_pkg::inv_mix(ak);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= word_d.vld;
    end
  end

  // hold payload when stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= word_d.state;
      rkey_q  <= word_d.rkey;
    end
  end

  assign word_o = '{vld: vld_q, state: state_q, rkey: rkey_q};
endmodule

### rtl/aes128_block_decrypt.sv
// Top level: pipelined AES-128 block decryption, one round cell per round.
// An accepted word passes through the ten round-cell registers to the output;
// one block per cycle unless stalled or held off; the cells advance together.
// A configuration write reexpands the key through a 10-cell forward chain:
// input is held off (ready low) while it refills after reset and each write.
// Reset (rst_ni low, asynchronous) clears the key, mode and all valid bits.
module aes128_block_decrypt (
  input  logic                clk_i,
  input  logic                rst_ni,
  aesd_cfg_if.sink            cfg,
  aesd_blk_if.sink            cipher,
  aesd_blk_if.source          plain
);
  localparam int unsigned N = aesd_pkg::NumRounds;

  logic [63:0] key_high_q, key_low_q;
  logic        key_mode_q;
  logic [3:0]  settle_q;
  aesd_pkg::block_t kchain [N+1];
  aesd_pkg::block_t last_key;
  aesd_pkg::cell_word_t word [N+1];
  logic adv;

  // store configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      key_mode_q <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        aesd_pkg::RegKeyHigh: key_high_q <= cfg.data;
        aesd_pkg::RegKeyLow:  key_low_q  <= cfg.data;
        aesd_pkg::RegKeyMode: key_mode_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // count down while the expansion chain refills after reset or a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 4'(N);
    end else if (cfg.valid) begin
      settle_q <= 4'(N);
    end else if (settle_q != 4'd0) begin
      settle_q <= settle_q - 4'd1;
    end
  end

  // forward expansion chain to the final round key
  assign kchain[0] = {key_high_q, key_low_q};
  for (genvar g = 0; g < N; g++) begin : g_kexp
    aesd_kexp_cell u_kexp (
      .clk_i  (clk_i),
      .step_i (4'(g)),
      .key_i  (kchain[g]),
      .key_o  (kchain[g+1])
    );
  end
  assign last_key = key_mode_q ? {key_high_q, key_low_q} : kchain[N];

  // advance the whole row unless the output word is stalled
  assign adv = !word[N].vld || plain.ready;
  assign cipher.ready = adv && (settle_q == 4'd0);

  assign word[0] = '{vld:   cipher.valid && (settle_q == 4'd0),
                     state: {cipher.data_high, cipher.data_low} ^ last_key,
                     rkey:  last_key};

  for (genvar g = 0; g < N; g++) begin : g_round
    aesd_round_cell u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .rnd_i  (4'(N - g)),
      .last_i (g == N - 1),
      .word_i (word[g]),
      .word_o (word[g+1])
    );
  end

  assign plain.valid     = word[N].vld;
  assign plain.data_high = word[N].state[127:64];
  assign plain.data_low  = word[N].state[63:0];

  // a stalled result stays valid and its high half holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plain.valid && !plain.ready |=> plain.valid && $stable(plain.data_high))
    else $error("result changed while stalled");
  // input is taken whenever the output is empty and the key is settled
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !plain.valid && (settle_q == 4'd0) |-> cipher.ready)
    else $error("input blocked with empty output");
  // a word accepted reaches the first cell
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cipher.valid && cipher.ready |=> g_round[0].u_round.vld_q)
    else $error("accepted word lost");
endmodule

### dv/tb_top.sv
// Testbench for the AES-128 block decryption pipeline: directed table, then random blocks.
module tb_top;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        chk;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vec_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } plain_t;

  logic clk_i;
  logic rst_ni;
  aesd_cfg_if cfg_bus ();
  aesd_blk_if cin ();
  aesd_blk_if pout ();

  aes128_block_decrypt dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_bus),
    .cipher (cin),
    .plain  (pout)
  );

  // Key copy held by the predictor
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic        key_last_q;

  plain_t plain_exp_q[$];
  int     errors;
  int     cycles;
  bit     done_stim;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: abort on a hung pipeline
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL aes128_block_decrypt");
      $finish;
    end
  end

  function automatic logic [7:0] isbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[a];
  endfunction

  // Forward S-box rebuilt once from the inverse table
  logic [7:0] fsb [256];
  initial begin
    for (int i = 0; i < 256; i++) fsb[isbox(i[7:0])] = i[7:0];
  end

  function automatic logic [7:0] rc_of(input int i);
    logic [7:0] r;
    r = 8'h01;
    for (int j = 0; j < i; j++) r = {r[6:0], 1'b0} ^ (r[7] ? 8'h1b : 8'h00);
    return r;
  endfunction

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Decrypt one block with the held key
  function automatic plain_t decrypt_block(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] k [16];
    logic [7:0] t [16];
    logic [7:0] a, m2, m4, m8, x;
    logic [7:0] c0, c1, c2, c3;
    logic [127:0] blk, kv;
    plain_t res;
    blk = {hi, lo};
    kv  = {key_hi_q, key_lo_q};
    for (int i = 0; i < 16; i++) begin
      s[i] = blk[127-8*i -: 8];
      k[i] = kv[127-8*i -: 8];
    end
    if (!key_last_q) begin
      for (int r = 0; r < 10; r++) begin
        c0 = fsb[k[13]] ^ rc_of(r); c1 = fsb[k[14]]; c2 = fsb[k[15]]; c3 = fsb[k[12]];
        k[0] ^= c0; k[1] ^= c1; k[2] ^= c2; k[3] ^= c3;
        for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
      end
    end
    for (int i = 0; i < 16; i++) s[i] ^= k[i];
    for (int r = 10; r >= 1; r--) begin
      // step the key schedule back one round
      for (int i = 15; i >= 4; i--) k[i] ^= k[i-4];
      k[0] ^= fsb[k[13]] ^ rc_of(r-1);
      k[1] ^= fsb[k[14]];
      k[2] ^= fsb[k[15]];
      k[3] ^= fsb[k[12]];
      for (int c = 0; c < 4; c++)
        for (int rw = 0; rw < 4; rw++)
          t[4*c+rw] = isbox(s[4*((c-rw+4)%4)+rw]);
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
      if (r > 1) begin
        for (int i = 0; i < 16; i++) begin
          // column multiply by {0e,0b,0d,09}: accumulate each term
          t[i] = 8'h00;
        end
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++) begin
            x = 8'h00;
            for (int j = 0; j < 4; j++) begin
              a = s[4*c+(rw+j)%4]; m2 = gmul2(a); m4 = gmul2(m2); m8 = gmul2(m4);
              case (j)
                0: x ^= m8 ^ m4 ^ m2;
                1: x ^= m8 ^ m2 ^ a;
                2: x ^= m8 ^ m4 ^ a;
                default: x ^= m8 ^ a;
              endcase
            end
            t[4*c+rw] = x;
          end
        for (int i = 0; i < 16; i++) s[i] = t[i];
      end
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    res.hi = blk[127:64];
    res.lo = blk[63:0];
    return res;
  endfunction

  // Random gap length: mostly short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic cfg_write(input logic [aesd_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == aesd_pkg::RegKeyHigh) key_hi_q = val;
    else if (idx == aesd_pkg::RegKeyLow) key_lo_q = val;
    else if (idx == aesd_pkg::RegKeyMode) key_last_q = val[0];
  endtask

  // Drain the pipeline, then let the key chain settle
  task automatic wait_idle();
    while (plain_exp_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo, input logic last);
    wait_idle();
    cfg_write(aesd_pkg::RegKeyHigh, hi);
    cfg_write(aesd_pkg::RegKeyLow, lo);
    cfg_write(aesd_pkg::RegKeyMode, {63'($urandom), last});
    repeat (12) @(posedge clk_i);
  endtask

  // Send one word; queue its prediction or typed expectation
  task automatic send_block(input vec_t v);
    plain_t p;
    int g;
    g = gap_len();
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      cin.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    cin.valid     <= 1'b1;
    cin.data_high <= v.hi;
    cin.data_low  <= v.lo;
    do @(posedge clk_i); while (!cin.ready);
    if (v.chk) begin
      p.hi = v.exp_hi;
      p.lo = v.exp_lo;
    end else begin
      p = decrypt_block(v.hi, v.lo);
    end
    plain_exp_q.push_back(p);
  endtask

  task automatic idle_input();
    cin.valid <= 1'b0;
  endtask

  // Output side: random stalls and comparison against the oldest expectation
  logic stall_run;
  int   stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    plain_t e;
    if (!rst_ni) begin
      pout.ready <= 1'b0;
      stall_cnt  <= 0;
    end else begin
      if (pout.valid && pout.ready) begin
        if (plain_exp_q.size() == 0) begin
          $display("%0t unexpected word: got %h_%h", $realtime, pout.data_high, pout.data_low);
          errors++;
        end else begin
          e = plain_exp_q.pop_front();
          if (pout.data_high !== e.hi) begin
            $display("%0t plain_high: expected %h actual %h", $realtime, e.hi, pout.data_high);
            errors++;
          end
          if (pout.data_low !== e.lo) begin
            $display("%0t plain_low: expected %h actual %h", $realtime, e.lo, pout.data_low);
            errors++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt  <= stall_cnt - 1;
        pout.ready <= 1'b0;
      end else if (stall_run || done_stim) begin
        pout.ready <= 1'b1;
      end else begin
        stall_cnt  <= gap_len();
        pout.ready <= 1'b1;
      end
    end
  end

  vec_t dir_tab [$];

  initial begin
    vec_t v;
    int   n;
    logic [63:0] rh, rl;
    errors        = 0;
    cycles        = 0;
    done_stim     = 0;
    stall_run     = 0;
    key_hi_q      = '0;
    key_lo_q      = '0;
    key_last_q    = 1'b0;
    rst_ni        = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = aesd_pkg::RegKeyHigh;
    cfg_bus.data  = '0;
    cin.valid     = 1'b0;
    cin.data_high = '0;
    cin.data_low  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (12) @(posedge clk_i);

    // Zero key after reset: a directed table of blocks checked by the predictor
    dir_tab.push_back('{64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
    dir_tab.push_back('{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0});
    dir_tab.push_back('{64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0});
    foreach (dir_tab[i]) send_block(dir_tab[i]);
    idle_input();

    // Standard cipher key and its known answer
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b0);
    v = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
          64'h0011223344556677, 64'h8899aabbccddeeff};
    send_block(v);
    v = '{64'h0, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0};
    send_block(v);
    idle_input();
    // Same key given as its last round key
    set_key(64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5, 1'b1);
    v = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
          64'h0011223344556677, 64'h8899aabbccddeeff};
    send_block(v);
    v = '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0};
    send_block(v);
    idle_input();
    set_key(64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0);
    v = '{64'hffffffffffffffff, 64'h0, 1'b0, 64'h0, 64'h0};
    send_block(v);
    idle_input();
    set_key(64'hffffffffffffffff, 64'hffffffffffffffff, 1'b1);
    v = '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0};
    send_block(v);
    idle_input();

    // Random phases: a fresh key each phase, blocks with random content
    for (int ph = 0; ph < 10; ph++) begin
      rh = {$urandom, $urandom};
      rl = {$urandom, $urandom};
      set_key(rh, rl, ph[0]);
      stall_run = (ph % 3 == 2);
      n = 50;
      for (int i = 0; i < n; i++) begin
        v.hi  = {$urandom, $urandom};
        v.lo  = {$urandom, $urandom};
        v.chk = 1'b0;
        send_block(v);
      end
      idle_input();
    end
    set_key(64'h0, 64'h0, 1'b1);
    v = '{64'h0, 64'h0, 1'b0, 64'h0, 64'h0};
    send_block(v);
    idle_input();

    done_stim = 1;
    while (plain_exp_q.size() != 0) @(posedge clk_i);
    repeat (15) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS aes128_block_decrypt");
    end else begin
      $display("FAIL aes128_block_decrypt");
    end
    $finish;
  end

endmodule
